// ===== rtl/core/bweg_pkg.sv =====
// Shared types, action codes and helpers for the Exp-Golomb bit writer.
// Used by bit_writer_exp_golomb; depends on nothing.
`default_nettype none

package bweg_pkg;

  typedef logic [1:0] action_t;

  localparam action_t ACT_RAW   = 2'd0;
  localparam action_t ACT_UE    = 2'd1;
  localparam action_t ACT_SE    = 2'd2;
  localparam action_t ACT_FLUSH = 2'd3;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned NBYTE_W = 3;

  localparam logic [CNT_W-1:0]    FULL_FREE = 6'd32;
  localparam logic [CODE_W-1:0]   UE_MAX    = 16'd65534;
  localparam logic [WORD_W-1:0]   SE_MAX    = 32'd32767;
  localparam logic [NBYTE_W-1:0]  WORD_BYTES = 3'd4;

  // Position of the highest set bit of a nonzero code word.
  function automatic logic [3:0] msb_pos(input logic [CODE_W-1:0] code);
    logic [3:0] pos;
    pos = 4'd0;
    for (int i = 0; i < CODE_W; i++) begin
      if (code[i]) begin
        pos = 4'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bit_writer_exp_golomb.sv =====
// Exp-Golomb bitstream writer: raw, unsigned and signed codes packed MSB first.
// Path: an item is held in the input register, then its bytes load the byte buffer that drives the output.
// Throughput: one item per cycle while no word fills; a filling write holds the byte buffer
//   for 4 transfers and a flush for 0 to 4, and the next emitting item waits for the last one.
// Reset (rst_n low, synchronous): accumulator empty, 32 free bits, no item or byte pending.
// Depends on bweg_pkg.
`default_nettype none

module bit_writer_exp_golomb (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [31:0] value, [37:32] bit_count, [39:38] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] action
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast   // final byte of the run caused by one input
);

  localparam int unsigned WW = bweg_pkg::WORD_W;
  localparam int unsigned CW = bweg_pkg::CNT_W;
  localparam int unsigned KW = bweg_pkg::CODE_W;
  localparam int unsigned NW = bweg_pkg::NBYTE_W;

  // ---------------------------------------------------------------------
  // Input register: one item waits here until its bytes can be queued.
  // ---------------------------------------------------------------------
  logic                     in_valid_r;
  bweg_pkg::action_t        act_r;
  logic [WW-1:0]            value_r;
  logic [CW-1:0]            count_r;

  // Packing state
  logic [WW-1:0]            acc_r, acc_nxt;
  logic [CW-1:0]            free_r, free_nxt;

  // Byte buffer on the result side
  logic [WW-1:0]            word_r, word_nxt;
  logic [NW-1:0]            cnt_r, cnt_nxt;

  logic                     proc_go;
  logic                     out_xfer;
  logic [NW-1:0]            emit_n;
  logic [WW-1:0]            emit_word;

  // ---------------------------------------------------------------------
  // Code construction
  // ---------------------------------------------------------------------
  logic [WW-1:0]            neg_mag;
  logic [14:0]              se_mag;
  logic [KW-1:0]            se_mapped;
  logic [KW-1:0]            ue_num;
  logic [KW-1:0]            code;
  logic [3:0]               lz;
  logic [CW-1:0]            raw_len;
  logic [CW-1:0]            len;
  logic [WW-1:0]            bits;
  logic                     skip;

  always_comb begin
    // signed map: 2|v| for v <= 0, 2v-1 for v > 0, magnitude saturated to 32767
    neg_mag = ~value_r + 32'd1;
    if (value_r[WW-1]) begin
      se_mag    = (neg_mag > bweg_pkg::SE_MAX) ? 15'h7FFF : neg_mag[14:0];
      se_mapped = {se_mag, 1'b0};
    end else begin
      se_mag    = (value_r > bweg_pkg::SE_MAX) ? 15'h7FFF : value_r[14:0];
      se_mapped = (se_mag == 15'd0) ? '0 : ({se_mag, 1'b0} - 16'd1);
    end

    if (act_r == bweg_pkg::ACT_UE) begin
      ue_num = (value_r > {16'd0, bweg_pkg::UE_MAX}) ? bweg_pkg::UE_MAX : value_r[KW-1:0];
    end else begin
      ue_num = se_mapped;
    end
    code = ue_num + 16'd1;
    lz   = bweg_pkg::msb_pos(code);

    // clamp raw length to a full word
    raw_len = (count_r > bweg_pkg::FULL_FREE) ? bweg_pkg::FULL_FREE : count_r;

    if (act_r == bweg_pkg::ACT_RAW) begin
      len  = raw_len;
      bits = value_r;
    end else begin
      len  = {1'b0, lz, 1'b1};
      bits = {16'd0, code};
    end
    skip = (act_r == bweg_pkg::ACT_RAW) && (count_r == '0);
  end

  // ---------------------------------------------------------------------
  // Accumulator update and bytes to emit
  // ---------------------------------------------------------------------
  logic [WW-1:0]            aligned;
  logic [WW-1:0]            acc_or;
  logic [CW-1:0]            used7;

  always_comb begin
    aligned   = bits << (bweg_pkg::FULL_FREE - len);
    acc_or    = acc_r | (aligned >> (bweg_pkg::FULL_FREE - free_r));
    used7     = 6'd39 - free_r;
    acc_nxt   = acc_r;
    free_nxt  = free_r;
    emit_n    = '0;
    emit_word = acc_r;
    if (act_r == bweg_pkg::ACT_FLUSH) begin
      // ceil(pending/8) bytes, zero padded, then empty
      emit_n    = used7[5:3];
      emit_word = acc_r;
      acc_nxt   = '0;
      free_nxt  = bweg_pkg::FULL_FREE;
    end else if (!skip) begin
      if (len < free_r) begin
        acc_nxt  = acc_or;
        free_nxt = free_r - len;
      end else begin
        // word fills: ship it, keep the spill bits
        emit_n    = bweg_pkg::WORD_BYTES;
        emit_word = acc_or;
        acc_nxt   = (free_r < bweg_pkg::FULL_FREE) ? (aligned << free_r) : '0;
        free_nxt  = bweg_pkg::FULL_FREE - (len - free_r);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------
  assign out_xfer   = out_tvalid && out_tready;
  // an item that emits needs the buffer empty or on its final transfer
  assign proc_go    = in_valid_r &&
                      ((emit_n == '0) || (cnt_r == '0) || ((cnt_r == 3'd1) && out_tready));
  assign in_tready  = !in_valid_r || proc_go;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = word_r[WW-1 -: bweg_pkg::BYTE_W];
  assign out_tlast  = (cnt_r == 3'd1);

  always_comb begin
    word_nxt = word_r;
    cnt_nxt  = cnt_r;
    if (proc_go && (emit_n != '0)) begin
      word_nxt = emit_word;
      cnt_nxt  = emit_n;
    end else if (out_xfer) begin
      // advance to the next byte
      word_nxt = word_r << bweg_pkg::BYTE_W;
      cnt_nxt  = cnt_r - 3'd1;
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      acc_r      <= '0;
      free_r     <= bweg_pkg::FULL_FREE;
      cnt_r      <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (proc_go) begin
        in_valid_r <= 1'b0;
      end
      if (proc_go) begin
        acc_r  <= acc_nxt;
        free_r <= free_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r   <= in_tuser;
      value_r <= in_tdata[WW-1:0];
      count_r <= in_tdata[WW+CW-1:WW];
    end
    word_r <= word_nxt;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r != '0) && (free_r <= bweg_pkg::FULL_FREE))
    else $error("free bit count out of range");

  a_buf_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bweg_pkg::WORD_BYTES)
    else $error("byte buffer holds more than one word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && (emit_n != '0)) |-> ((cnt_r == '0) || ((cnt_r == 3'd1) && out_tready)))
    else $error("byte buffer loaded while bytes still pending");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && (act_r == bweg_pkg::ACT_FLUSH)) |=>
      ((free_r == bweg_pkg::FULL_FREE) && (acc_r == '0)))
    else $error("flush left pending bits");

endmodule

`default_nettype wire
